// File: hdl/sed_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sed_pkg
// Shared types and constants for the streaming Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sed_pkg;

	localparam int PIX_W     = 8;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 1;

	typedef logic [PIX_W-1:0] pix_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH  = 1'b0,
		CFG_FRAME_HEIGHT = 1'b1
	} cfg_idx_t;

	// per-word control that travels with a pixel down the pipe
	typedef struct packed {
		logic res;     // word completes a window: one result word
		logic last;    // result is the frame's final pixel
		logic mtop;    // window top row outside the frame
		logic mbot;    // window bottom row outside the frame
		logic mleft;   // window left column outside the frame
		logic mright;  // window right column outside the frame
	} sed_flags_t;

endpackage
`default_nettype wire

// File: hdl/sed_pix_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sed_pix_if
// Valid/ready channel carrying one gray pixel per word.
// ----------------------------------------------------------------------------
interface sed_pix_if import sed_pkg::*;;
	logic valid;
	logic ready;
	pix_t pixel_in;

	modport source (output valid, output pixel_in, input ready);
	modport sink (input valid, input pixel_in, output ready);
endinterface
`default_nettype wire

// File: hdl/sed_res_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sed_res_if
// Valid/ready channel carrying one edge magnitude result per word.
// ----------------------------------------------------------------------------
interface sed_res_if import sed_pkg::*;;
	logic valid;
	logic ready;
	pix_t edge_value;
	logic frame_last;

	modport source (output valid, output edge_value, output frame_last, input ready);
	modport sink (input valid, input edge_value, input frame_last, output ready);
endinterface
`default_nettype wire

// File: hdl/sed_pos.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sed_pos
// Frame geometry registers and raster position tracker. Derives the border
// masks, result flag and frame-end flag for each accepted word.
// ----------------------------------------------------------------------------
module sed_pos import sed_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	localparam int CW = $clog2(MAX_WIDTH),
	localparam int WW = $clog2(MAX_WIDTH + 1),
	localparam int HW = $clog2(MAX_HEIGHT + 1),
	localparam int RW = $clog2(MAX_HEIGHT + 4)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 acc,
	input  wire pix_t                 pixel_in,
	output logic      [CW-1:0]        col,
	output pix_t                      pix,
	output sed_flags_t                flags
);

	localparam logic [WW-1:0] W_RST = WW'((MAX_WIDTH < 640) ? MAX_WIDTH : 640);
	localparam logic [HW-1:0] H_RST = HW'((MAX_HEIGHT < 480) ? MAX_HEIGHT : 480);

	function automatic logic [31:0] clamp_dim(input logic [CFG_W-1:0] v, input int hi);
		logic [31:0] vx;
		vx = 32'(v);
		if (vx == 32'd0) begin
			return 32'd1;
		end else if (vx > 32'(hi)) begin
			return 32'(hi);
		end
		return vx;
	endfunction

	logic [WW-1:0] w_q;
	logic [HW-1:0] h_q;
	logic [RW-1:0] hp1_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	logic          wrap;
	logic [CW-1:0] col_a;
	logic [RW-1:0] row_a;
	logic          restart;
	logic [CW-1:0] col0;
	logic [RW-1:0] row0;
	logic [RW-1:0] h_x;
	logic          cz;
	logic [WW-1:0] col1;
	logic          nxt_wrap;
	logic [31:0]   cfg_dim;

	always_comb begin
		cfg_dim = clamp_dim(cfg_data, MAX_WIDTH);
		if (cfg_idx_t'(cfg_index) == CFG_FRAME_HEIGHT) begin
			cfg_dim = clamp_dim(cfg_data, MAX_HEIGHT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q   <= W_RST;
			h_q   <= H_RST;
			hp1_q <= RW'(H_RST) + RW'(1);
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_FRAME_WIDTH: begin
					w_q <= cfg_dim[WW-1:0];
				end
				CFG_FRAME_HEIGHT: begin
					h_q   <= cfg_dim[HW-1:0];
					hp1_q <= cfg_dim[RW-1:0] + RW'(1);
				end
				default: begin
					w_q <= w_q;
				end
			endcase
		end
	end

	always_comb begin
		h_x     = RW'(h_q);
		wrap    = WW'(col_q) >= w_q;
		col_a   = wrap ? '0 : col_q;
		row_a   = wrap ? row_q + RW'(1) : row_q;
		restart = (row_a > hp1_q) || ((row_a == hp1_q) && (col_a != '0));
		col0    = restart ? '0 : col_a;
		row0    = restart ? '0 : row_a;
		cz      = col0 == '0;

		flags.res    = (row0 >= RW'(2)) || ((row0 == RW'(1)) && !cz);
		flags.last   = (row0 == hp1_q) && cz;
		flags.mtop   = (!cz && (row0 == RW'(1))) || (cz && (row0 == RW'(2)));
		flags.mbot   = (!cz && (row0 == h_x)) || (cz && (row0 == hp1_q));
		flags.mleft  = (col0 == CW'(1)) || (cz && (w_q == WW'(1)));
		flags.mright = cz;

		pix      = (row0 < h_x) ? pixel_in : '0;
		col      = col0;
		col1     = WW'(col0) + WW'(1);
		nxt_wrap = col1 >= w_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			col_q <= nxt_wrap ? '0 : col1[CW-1:0];
			row_q <= nxt_wrap ? row0 + RW'(1) : row0;
		end
	end

endmodule
`default_nettype wire

// File: hdl/sed_window.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sed_window
// Two line stores with registered reads and a 3x3 pixel window. A word that
// reads the column written on the same edge takes the written data instead.
// ----------------------------------------------------------------------------
module sed_window import sed_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	localparam int CW = $clog2(MAX_WIDTH)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              adv,
	input  wire logic              acc,
	input  wire logic [CW-1:0]     col_in,
	input  wire pix_t              pix_in,
	input  wire sed_flags_t        flags_in,
	output pix_t       [8:0]       win,
	output sed_flags_t             flags_s2,
	output logic                   v_s2
);

	pix_t mem_top [MAX_WIDTH];
	pix_t mem_mid [MAX_WIDTH];

	pix_t          top_rd_s1;
	pix_t          mid_rd_s1;
	logic [CW-1:0] col_s1;
	pix_t          pix_s1;
	sed_flags_t    flags_s1;
	logic          v_s1;
	logic          byp_hit_q;
	pix_t          byp_top_q;
	pix_t          byp_mid_q;
	pix_t [8:0]    win_q;
	pix_t          top_eff;
	pix_t          mid_eff;

	assign top_eff = byp_hit_q ? byp_top_q : top_rd_s1;
	assign mid_eff = byp_hit_q ? byp_mid_q : mid_rd_s1;

	always_ff @(posedge clk) begin
		if (acc) begin
			top_rd_s1 <= mem_top[col_in];
			mid_rd_s1 <= mem_mid[col_in];
			col_s1    <= col_in;
			pix_s1    <= pix_in;
			flags_s1  <= flags_in;
		end
		if (adv && v_s1) begin
			mem_top[col_s1] <= mid_eff;
			mem_mid[col_s1] <= pix_s1;
			flags_s2        <= flags_s1;
		end
		if (adv) begin
			byp_top_q <= mid_eff;
			byp_mid_q <= pix_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			byp_hit_q <= 1'b0;
			win_q     <= '0;
		end else if (adv) begin
			v_s1      <= acc;
			v_s2      <= v_s1;
			byp_hit_q <= acc && v_s1 && (col_in == col_s1);
			if (v_s1) begin
				for (int r = 0; r < 3; r++) begin
					win_q[r*3]   <= win_q[r*3+1];
					win_q[r*3+1] <= win_q[r*3+2];
				end
				win_q[2] <= top_eff;
				win_q[5] <= mid_eff;
				win_q[8] <= pix_s1;
			end
		end
	end

	assign win = win_q;

endmodule
`default_nettype wire

// File: hdl/sed_kernel.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sed_kernel
// Border masking, Sobel gradients, L1 magnitude with saturation, and the
// output word register.
// ----------------------------------------------------------------------------
module sed_kernel import sed_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         adv,
	input  wire pix_t [8:0]   win,
	input  wire sed_flags_t   flags,
	input  wire logic         vld,
	output logic              out_vld,
	output pix_t              edge_value,
	output logic              frame_last
);

	localparam logic [8:0] KILL_TOP   = 9'h007;
	localparam logic [8:0] KILL_BOT   = 9'h1C0;
	localparam logic [8:0] KILL_LEFT  = 9'h049;
	localparam logic [8:0] KILL_RIGHT = 9'h124;

	logic [8:0]  kill;
	logic [9:0]  v [9];
	logic [9:0]  sx_p, sx_n, sy_p, sy_n;
	logic [9:0]  ax, ay;
	logic [10:0] mag;
	pix_t        mag_sat;

	logic        vld_q;
	pix_t        val_q;
	logic        last_q;

	always_comb begin
		kill = ({9{flags.mtop}} & KILL_TOP) | ({9{flags.mbot}} & KILL_BOT) |
		       ({9{flags.mleft}} & KILL_LEFT) | ({9{flags.mright}} & KILL_RIGHT);
		for (int i = 0; i < 9; i++) begin
			v[i] = kill[i] ? 10'd0 : 10'(win[i]);
		end
		sx_p = v[2] + (v[5] << 1) + v[8];
		sx_n = v[0] + (v[3] << 1) + v[6];
		sy_p = v[6] + (v[7] << 1) + v[8];
		sy_n = v[0] + (v[1] << 1) + v[2];
		ax   = (sx_p >= sx_n) ? sx_p - sx_n : sx_n - sx_p;
		ay   = (sy_p >= sy_n) ? sy_p - sy_n : sy_n - sy_p;
		mag  = 11'(ax) + 11'(ay);
		mag_sat = (mag > 11'd255) ? 8'hFF : mag[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= vld && flags.res;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			val_q  <= mag_sat;
			last_q <= flags.last;
		end
	end

	assign out_vld    = vld_q;
	assign edge_value = val_q;
	assign frame_last = last_q;

endmodule
`default_nettype wire

// File: hdl/sobel_edge_magnitude_stream.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_stream
// Streaming 3x3 Sobel edge detector, L1 magnitude saturated to 255.
//
//   channel | dir | payload                    | handshake
//   --------+-----+----------------------------+------------------
//   pix     | in  | pixel_in[7:0]              | valid/ready
//   res     | out | edge_value[7:0], frame_last| valid/ready
//   cfg     | in  | cfg_index, cfg_data[10:0]  | cfg_we, no ready
//
// One word per cycle in, one result per cycle out. The word that completes
// a window (pixel p + frame width + 1) passes the line-store read register
// and the window register, and its result then enters the output register.
// Reset clears position, window and valid bits; line stores are not cleared
// and need no sweep. When the output word is held, the whole pipe holds and pix.ready drops.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_stream import sed_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	sed_pix_if.sink                   pix,
	sed_res_if.source                 res,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic          adv;
	logic          acc;
	logic          out_vld;
	logic [CW-1:0] col;
	pix_t          pix_m;
	sed_flags_t    flags_s0;
	pix_t [8:0]    win;
	sed_flags_t    flags_s2;
	logic          v_s2;

	assign adv       = !out_vld || res.ready;
	assign acc       = pix.valid && adv;
	assign pix.ready = adv;
	assign res.valid = out_vld;

	sed_pos #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_pos (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.acc       (acc),
		.pixel_in  (pix.pixel_in),
		.col       (col),
		.pix       (pix_m),
		.flags     (flags_s0)
	);

	sed_window #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.acc      (acc),
		.col_in   (col),
		.pix_in   (pix_m),
		.flags_in (flags_s0),
		.win      (win),
		.flags_s2 (flags_s2),
		.v_s2     (v_s2)
	);

	sed_kernel u_kernel (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.win        (win),
		.flags      (flags_s2),
		.vld        (v_s2),
		.out_vld    (out_vld),
		.edge_value (res.edge_value),
		.frame_last (res.frame_last)
	);

endmodule
`default_nettype wire

// File: bench/sobel_edge_magnitude_stream_tb.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_stream_tb
// Self-checking bench for the streaming Sobel edge magnitude block. Frames
// of gray pixels go in with drain words after each frame. A behavioral
// Sobel pipe predicts every edge word, and each arriving word is checked
// field by field. Frame geometry moves from 1x1 up to full height, with
// clamped register values. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_stream_tb;
	import sed_pkg::*;

	localparam int MAX_W      = 1024;
	localparam int MAX_H      = 1024;
	localparam int QUIET_MAX  = 1000;
	localparam int RAND_PIXELS = 300;

	typedef struct {
		pix_t edge_value;
		logic frame_last;
	} edge_word_t;

	typedef enum {
		PAT_RANDOM, PAT_ZERO, PAT_FLAT, PAT_CHECKER, PAT_SPOT, PAT_RAMP
	} frame_pattern_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	sed_pix_if pix ();
	sed_res_if res ();

	sobel_edge_magnitude_stream #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pix      (pix),
		.res      (res),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// predicted pipe state
	logic [CFG_W-1:0] geom_w;
	logic [CFG_W-1:0] geom_h;
	pix_t row_above[MAX_W];
	pix_t row_prev[MAX_W];
	pix_t win[9];
	int unsigned pos_col;
	int unsigned pos_row;

	edge_word_t pending_edges[$];
	int errors;
	int quiet;
	int frames_sent;
	int pixels_sent;
	int edges_checked;
	bit steady;
	bit hold_for_results;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic int dim_clamp(input logic [CFG_W-1:0] v, input int hi);
		if (v == 0) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	// true when the next word opens a frame at row 0, column 0
	function automatic bit at_frame_start();
		int w, h, c, r, t;
		w = dim_clamp(geom_w, MAX_W);
		h = dim_clamp(geom_h, MAX_H);
		c = pos_col;
		r = pos_row;
		if (c >= w) begin
			c = 0;
			r++;
		end
		t = r * w + c;
		return (r > h + 1 || t > w * h + w || t == 0);
	endfunction

	function automatic bit sobel_step(input pix_t px_in, output pix_t mag,
		output logic at_last);
		int w, h, total, t, p, cr, cc, gx, gy, g;
		int v[9];
		pix_t px, top, mid;
		bit has;
		w = dim_clamp(geom_w, MAX_W);
		h = dim_clamp(geom_h, MAX_H);
		total = w * h;
		mag = '0;
		at_last = 1'b0;
		has = 1'b0;
		if (pos_col >= w) begin
			pos_col = 0;
			pos_row++;
		end
		t = pos_row * w + pos_col;
		if (pos_row > h + 1 || t > total + w) begin
			pos_row = 0;
			pos_col = 0;
			t = 0;
		end
		px = (pos_row < h) ? px_in : '0;
		top = row_above[pos_col];
		mid = row_prev[pos_col];
		row_above[pos_col] = mid;
		row_prev[pos_col] = px;
		for (int r = 0; r < 3; r++) begin
			win[r*3] = win[r*3+1];
			win[r*3+1] = win[r*3+2];
		end
		win[2] = top;
		win[5] = mid;
		win[8] = px;
		if (t >= w + 1 && t - (w + 1) < total) begin
			p = t - (w + 1);
			cr = p / w;
			cc = p % w;
			for (int i = 0; i < 9; i++) v[i] = win[i];
			if (cr == 0) begin
				v[0] = 0; v[1] = 0; v[2] = 0;
			end
			if (cr == h - 1) begin
				v[6] = 0; v[7] = 0; v[8] = 0;
			end
			if (cc == 0) begin
				v[0] = 0; v[3] = 0; v[6] = 0;
			end
			if (cc == w - 1) begin
				v[2] = 0; v[5] = 0; v[8] = 0;
			end
			gx = -v[0] + v[2] - 2 * v[3] + 2 * v[5] - v[6] + v[8];
			gy = -v[0] - 2 * v[1] - v[2] + v[6] + 2 * v[7] + v[8];
			g = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
			if (g > 255) g = 255;
			mag = pix_t'(g);
			at_last = (p == total - 1);
			has = 1'b1;
		end
		pos_col++;
		if (pos_col >= w) begin
			pos_col = 0;
			pos_row++;
		end
		return has;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH %s: got %0d expected %0d (edge word %0d)",
			what, got, want, edges_checked);
		errors++;
	endtask

	task automatic send_word(input pix_t px);
		pix_t mag;
		logic lastf;
		edge_word_t e;
		while (!steady && $urandom_range(99) < 10) begin
			pix.valid <= 1'b0;
			@(posedge clk);
		end
		pix.valid <= 1'b1;
		pix.pixel_in <= px;
		do @(posedge clk); while (!pix.ready);
		if (sobel_step(px, mag, lastf)) begin
			e.edge_value = mag;
			e.frame_last = lastf;
			pending_edges.push_back(e);
		end
	endtask

	task automatic finish_phase();
		pix.valid <= 1'b0;
		do @(posedge clk); while (pending_edges.size() != 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		cfg_we <= 1'b1;
		cfg_index <= CFG_FRAME_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		geom_w = w;
		cfg_index <= CFG_FRAME_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		geom_h = h;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_frame(input frame_pattern_t pat);
		int w, h;
		pix_t px;
		// a geometry change can leave the position mid-frame: fill to the wrap
		while (!at_frame_start()) send_word(pix_t'($urandom_range(255)));
		w = dim_clamp(geom_w, MAX_W);
		h = dim_clamp(geom_h, MAX_H);
		for (int r = 0; r < h; r++) begin
			for (int c = 0; c < w; c++) begin
				if (hold_for_results && r * w + c == (w * h) / 2) begin
					hold_for_results = 1'b0;
					pix.valid <= 1'b0;
					do @(posedge clk); while (pending_edges.size() != 0);
				end
				case (pat)
					PAT_ZERO: px = 8'd0;
					PAT_FLAT: px = 8'd255;
					PAT_CHECKER: px = ((r + c) & 1) ? 8'd255 : 8'd0;
					PAT_SPOT: px = (r == h / 2 && c == w / 2) ? 8'd255 : 8'd0;
					PAT_RAMP: px = pix_t'(c * 37 + r * 91);
					default: px = pix_t'($urandom_range(255));
				endcase
				send_word(px);
				pixels_sent++;
			end
		end
		// drain words: pixel value must be ignored
		repeat (w + 1) send_word(pix_t'($urandom_range(255)));
		frames_sent++;
	endtask

	task automatic test_clamped_geometry();
		set_geometry(11'd0, 11'd0);
		send_frame(PAT_RAMP);
		finish_phase();
		set_geometry(11'd0, 11'd2047);
		send_frame(PAT_RANDOM);
		finish_phase();
	endtask

	task automatic test_kernel_patterns();
		set_geometry(11'd3, 11'd3);
		send_frame(PAT_ZERO);
		send_frame(PAT_FLAT);
		send_frame(PAT_SPOT);
		send_frame(PAT_CHECKER);
		finish_phase();
		set_geometry(11'd1, 11'd1);
		send_frame(PAT_FLAT);
		send_frame(PAT_SPOT);
		finish_phase();
		set_geometry(11'd3, 11'd1);
		send_frame(PAT_CHECKER);
		finish_phase();
		set_geometry(11'd1, 11'd3);
		send_frame(PAT_FLAT);
		finish_phase();
		set_geometry(11'd4, 11'd2);
		send_frame(PAT_CHECKER);
		finish_phase();
	endtask

	task automatic test_random_frames();
		int start, sel, reps;
		logic [CFG_W-1:0] w, h;
		frame_pattern_t pat;
		start = pixels_sent;
		hold_for_results = 1'b1;
		while (pixels_sent - start < RAND_PIXELS) begin
			sel = $urandom_range(99);
			if (sel < 80) begin
				w = CFG_W'($urandom_range(16, 1));
				h = CFG_W'($urandom_range(12, 1));
			end else if (sel < 90) begin
				w = CFG_W'($urandom_range(64, 17));
				h = CFG_W'($urandom_range(4, 1));
			end else begin
				w = 11'd0;
				h = CFG_W'($urandom_range(40, 0));
			end
			set_geometry(w, h);
			reps = $urandom_range(3, 1);
			repeat (reps) begin
				steady = (pixels_sent - start >= 100 && pixels_sent - start < 220);
				pat = ($urandom_range(7) == 0) ?
					frame_pattern_t'($urandom_range(PAT_RAMP)) : PAT_RANDOM;
				send_frame(pat);
			end
			finish_phase();
		end
		steady = 1'b0;
	endtask

	always @(posedge clk) begin
		edge_word_t e;
		if (arst_n && res.valid && res.ready) begin
			if (pending_edges.size() == 0) begin
				report_mismatch("unexpected edge word", res.edge_value, -1);
			end else begin
				e = pending_edges.pop_front();
				if (res.edge_value !== e.edge_value)
					report_mismatch("edge_value", res.edge_value, e.edge_value);
				if (res.frame_last !== e.frame_last)
					report_mismatch("frame_last", res.frame_last, e.frame_last);
			end
			edges_checked++;
		end
		if ((pix.valid && pix.ready) || (res.valid && res.ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_MAX) begin
			$display("timeout: no word moved for %0d cycles", QUIET_MAX);
			$display("DONE: errors detected");
			$finish;
		end
		res.ready <= steady || ($urandom_range(99) >= 10);
	end

	initial begin
		errors = 0;
		quiet = 0;
		frames_sent = 0;
		pixels_sent = 0;
		edges_checked = 0;
		steady = 1'b0;
		hold_for_results = 1'b0;
		geom_w = 11'd640;
		geom_h = 11'd480;
		foreach (row_above[i]) row_above[i] = '0;
		foreach (row_prev[i]) row_prev[i] = '0;
		foreach (win[i]) win[i] = '0;
		pos_col = 0;
		pos_row = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_FRAME_WIDTH;
		cfg_data = '0;
		pix.valid = 1'b0;
		pix.pixel_in = '0;
		res.ready = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_clamped_geometry();
		test_kernel_patterns();
		test_random_frames();

		if (pending_edges.size() != 0)
			report_mismatch("edge words never delivered", 0, pending_edges.size());
		$display("covered %0d frames, %0d pixel words, %0d edge words checked",
			frames_sent, pixels_sent, edges_checked);
		$display("geometry 1x1 to 64 wide and 1024 tall, clamped registers, random stalls");
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
